FILE: sv/mwr_pkg.sv
package mwr_pkg;

   localparam int TABLE_SIZE     = 2048;
   localparam int MIP_LEVELS     = 5;
   localparam int WAVE_COUNT     = 8;
   localparam int MIN_LEVEL_SIZE = 128;

   localparam int SAMPLE_W    = 16;
   localparam int SIZE_W      = $clog2(TABLE_SIZE + 1);
   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int STORE_DEPTH = 2 * WAVE_COUNT * MIP_LEVELS * TABLE_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [16:0] FADE_ONE    = 17'd65536;
   localparam logic [16:0] SWAP_READY  = 17'd64226;
   localparam logic [16:0] OLD_IGNORED = 17'd65471;
   localparam int          LEVEL_OFFSET = 51;
   localparam logic [17:0] RATE_FLOOR  = 18'd1000;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SWAP  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] CSR_MORPH       = 2'd1;
   localparam logic [1:0] CSR_BLEND_STEP  = 2'd2;

   typedef struct packed {
      logic                          we;
      logic [ADDR_W-1:0]             addr;
      logic signed [SAMPLE_W-1:0]    wdata;
   } store_req_type;

   // log2 in Q.8 of a Q.24 value, same truncating-squaring method as the datapath
   function automatic int log2_q8_const(input longint unsigned q);
      int          e;
      int          fr;
      logic [65:0] m;
      e = 0;
      for (int k = 0; k < 63; k++) begin
         if ((q >> (k + 1)) != 0) e = k + 1;
      end
      if (e >= 31) m = 66'(q >> (e - 31));
      else m = 66'(q) << (31 - e);
      fr = 0;
      for (int k = 0; k < 8; k++) begin
         m = (m * m) >> 31;
         fr = fr << 1;
         if (m >= 66'h1_0000_0000) begin
            fr = fr | 1;
            m = m >> 1;
         end
      end
      return (e - 24) * 256 + fr;
   endfunction

   localparam int LMAX_RAW = log2_q8_const((64'(TABLE_SIZE) << 24) / MIN_LEVEL_SIZE);
   localparam int LMAX     = (LMAX_RAW < 0) ? 0 : LMAX_RAW;
   localparam int MAX_LVL  = (MIP_LEVELS - 1) * 256;

endpackage

FILE: sv/mwr_mul.sv
module mwr_mul (
   input  logic                                clock,
   input  logic signed [mwr_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [mwr_pkg::MUL_W-1:0]    mul_b,
   output logic signed [mwr_pkg::PROD_W-1:0]   mul_p
);

   logic signed [mwr_pkg::PROD_W-1:0] prod_ff;
   logic signed [mwr_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

FILE: sv/mwr_store.sv
module mwr_store (
   input  logic                                  clock,
   input  mwr_pkg::store_req_type                req,
   output logic signed [mwr_pkg::SAMPLE_W-1:0]   rdata
);

   logic signed [mwr_pkg::SAMPLE_W-1:0] mem [mwr_pkg::STORE_DEPTH];
   logic signed [mwr_pkg::SAMPLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/mipmapped_wavetable_readout.sv
// Mipmapped morph-wavetable readout with two table banks and a bank crossfade.
// One command word at a time: a table write (command 0) gives no result; a swap
// (command 1) passes through the emit state before its answer is registered; a read
// (command 2) takes longest while a crossfade still mixes in the old bank, and is
// shortest before any bank has been made active. A read's time is set by the
// bit-serial divider, the leading-one search (longest for low pitch at a high rate),
// eight squarings for the log2 fraction, and then by the single table port and the
// single shared multiplier, which serve every tap: four table reads and three
// multiplies per Hermite tap, 4 or 8 taps per read, plus a multiply per blend stage.
// The next word is taken only once the block is back in idle; a finished result waits
// in the output register. The table holds garbage after reset until written; there is
// no clearing pass.
module mipmapped_wavetable_readout (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // wave_select[2:0], mip_level[5:3], entry_index[16:6], entry_value[32:17],
   // phase[56:33], frequency[80:57], zero fill above
   input  logic [87:0]  req_tdata,
   // command[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sample_out[15:0]
   output logic [15:0]  rsp_tdata,
   // is_read[0], swap_taken[1]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [17:0]  csr_wdata
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DIV   = 5'd1;
   localparam logic [4:0] S_NORM  = 5'd2;
   localparam logic [4:0] S_SQ_M  = 5'd3;
   localparam logic [4:0] S_SQ_W  = 5'd4;
   localparam logic [4:0] S_LVL   = 5'd5;
   localparam logic [4:0] S_POS_M = 5'd6;
   localparam logic [4:0] S_POS_W = 5'd7;
   localparam logic [4:0] S_RD    = 5'd8;
   localparam logic [4:0] S_HRN_M = 5'd9;
   localparam logic [4:0] S_HRN_W = 5'd10;
   localparam logic [4:0] S_LB_M  = 5'd11;
   localparam logic [4:0] S_LB_W  = 5'd12;
   localparam logic [4:0] S_WF_M  = 5'd13;
   localparam logic [4:0] S_WF_W  = 5'd14;
   localparam logic [4:0] S_XF_M  = 5'd15;
   localparam logic [4:0] S_XF_W  = 5'd16;
   localparam logic [4:0] S_EMIT  = 5'd17;

   localparam int DIVD_W = 24 + mwr_pkg::SIZE_W + 16;
   localparam int SW     = mwr_pkg::SIZE_W;
   localparam int IW     = mwr_pkg::IDX_W;
   localparam int MW     = mwr_pkg::MUL_W;
   localparam int PW     = mwr_pkg::PROD_W;
   localparam int AW     = mwr_pkg::ADDR_W;

   function automatic logic [SW-1:0] level_size(input logic [2:0] l);
      logic [SW-1:0] s;
      s = SW'(mwr_pkg::TABLE_SIZE);
      for (int k = 0; k < 8; k++) begin
         if (3'(k) < l) begin
            s = s >> 1;
            if (s < SW'(mwr_pkg::MIN_LEVEL_SIZE)) s = SW'(mwr_pkg::MIN_LEVEL_SIZE);
         end
      end
      return s;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic b, input logic [2:0] w,
                                             input logic [2:0] l, input logic [IW-1:0] i);
      logic [AW-1:0] a;
      a = AW'(b) * AW'(mwr_pkg::WAVE_COUNT) + AW'(w);
      a = a * AW'(mwr_pkg::MIP_LEVELS) + AW'(l);
      a = a * AW'(mwr_pkg::TABLE_SIZE) + AW'(i);
      return a;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      if (v > 36'sd32767) return 16'sh7fff;
      if (v < -36'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // registers
   logic [4:0]   state_ff, state_in;
   logic [16:0]  cf_ff, cf_in;
   logic         bank_ff, bank_in, act_v_ff, act_v_in, prev_v_ff, prev_v_in;
   logic [17:0]  sr_ff, sr_in;
   logic [15:0]  morph_ff, morph_in, step_ff, step_in;
   logic [23:0]  phase_ff, phase_in;
   logic [17:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0] qd_ff, qd_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [5:0]   e_ff, e_in;
   logic [31:0]  m_ff, m_in;
   logic [7:0]   fr_ff, fr_in;
   logic [2:0]   l0_ff, l0_in, l1_ff, l1_in;
   logic [7:0]   lb_ff, lb_in;
   logic         bsel_ff, bsel_in, wsel_ff, wsel_in, lsel_ff, lsel_in;
   logic [IW-1:0] i0_ff, i0_in;
   logic [15:0]  t_ff, t_in;
   logic signed [15:0] x_ff [4];
   logic signed [15:0] x_in [4];
   logic signed [23:0] acc_ff, acc_in;
   logic signed [15:0] a0_ff, a0_in, a1_ff, a1_in, wa_ff, wa_in, wb_ff, wb_in;
   logic signed [15:0] curr_ff, curr_in, old_ff, old_in, res_ff, res_in;
   logic         isr_ff, isr_in, tk_ff, tk_in;
   logic         rsp_v_ff, rsp_v_in;
   logic [15:0]  rsp_d_ff, rsp_d_in;
   logic [1:0]   rsp_u_ff, rsp_u_in;

   // shared units
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   mwr_pkg::store_req_type st_req;
   logic signed [15:0] st_rdata;

   mwr_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));
   mwr_store u_store (.clock(clock), .req(st_req), .rdata(st_rdata));

   // input fields
   logic [2:0]  in_wave, in_lvl;
   logic [IW-1:0] in_idx;
   logic signed [15:0] in_val;
   logic [23:0] in_phase, in_freq;
   logic        accept;

   assign in_wave  = req_tdata[2:0];
   assign in_lvl   = req_tdata[5:3];
   assign in_idx   = req_tdata[16:6];
   assign in_val   = req_tdata[32:17];
   assign in_phase = req_tdata[56:33];
   assign in_freq  = req_tdata[80:57];
   assign req_tready = (state_ff == S_IDLE);
   assign accept   = req_tvalid && req_tready;

   // combinational helpers
   logic [23:0] mag_raw, mag;
   logic [17:0] sr_eff;
   logic [DIVD_W-17:0] mag_ts;
   logic [18:0] div_r;
   logic        div_ge;
   logic [32:0] sq_sh;
   logic signed [15:0] raw, raw_c, lvl_s;
   logic [10:0] lvl_c;
   logic [18:0] mq;
   logic [2:0]  w0, w1, tw, tl;
   logic [15:0] wf;
   logic        tb;
   logic [SW-1:0] sz, i0x, im1, i1s, i1, i2s, i2, ridx;
   logic signed [23:0] xm1, x0, x1, x2, c1, c2, c3, hadd, acc_nx, acc_half;
   logic signed [PW-1:0] p8, p16;
   logic signed [16:0] d_lb, d_wf, d_xf;
   logic signed [15:0] tap_v, wv, bv, xv;
   logic        need_old, fin;
   logic signed [15:0] fin_v;
   logic [17:0] cf_sum;
   logic        wr_ok;

   assign mag_raw = in_freq[23] ? 24'(25'h100_0000 - 25'(in_freq)) : in_freq;
   assign mag     = (mag_raw < 24'd256) ? 24'd256 : mag_raw;
   assign mag_ts  = (DIVD_W - 16)'(mag) * (DIVD_W - 16)'(mwr_pkg::TABLE_SIZE);
   assign sr_eff  = (sr_ff < mwr_pkg::RATE_FLOOR) ? mwr_pkg::RATE_FLOOR : sr_ff;
   assign div_r   = {rem_ff, qd_ff[DIVD_W-1]};
   assign div_ge  = div_r >= {1'b0, sr_eff};
   assign sq_sh   = mul_p[63:31];

   assign raw = $signed({2'b0, e_ff, 8'b0}) - 16'sd6144 + $signed({8'b0, fr_ff});
   always_comb begin
      raw_c = raw;
      if (raw_c > 16'(mwr_pkg::LMAX)) raw_c = 16'(mwr_pkg::LMAX);
      if (raw_c < 16'sd0) raw_c = 16'sd0;
      lvl_s = raw_c + 16'(mwr_pkg::LEVEL_OFFSET);
      if (lvl_s > 16'(mwr_pkg::MAX_LVL)) lvl_s = 16'(mwr_pkg::MAX_LVL);
      lvl_c = lvl_s[10:0];
   end

   assign mq = 19'(morph_ff) * 19'(mwr_pkg::WAVE_COUNT - 1);
   assign wf = mq[15:0];
   always_comb begin
      w0 = (mq[18:16] > 3'(mwr_pkg::WAVE_COUNT - 1)) ? 3'(mwr_pkg::WAVE_COUNT - 1) : mq[18:16];
      w1 = (4'(w0) + 4'd1 < 4'(mwr_pkg::WAVE_COUNT)) ? w0 + 3'd1
                                                      : 3'(mwr_pkg::WAVE_COUNT - 1);
   end

   assign tb  = bsel_ff ? ~bank_ff : bank_ff;
   assign tw  = wsel_ff ? w1 : w0;
   assign tl  = lsel_ff ? l1_ff : l0_ff;
   assign sz  = level_size(tl);
   assign i0x = SW'(i0_ff);
   assign im1 = (i0_ff == '0) ? sz - SW'(1) : i0x - SW'(1);
   assign i1s = i0x + SW'(1);
   assign i1  = (i1s == sz) ? '0 : i1s;
   assign i2s = i0x + SW'(2);
   assign i2  = (i2s >= sz) ? i2s - sz : i2s;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: ridx = im1;
         2'd1: ridx = i0x;
         2'd2: ridx = i1;
         default: ridx = i2;
      endcase
   end

   // Hermite coefficients
   assign xm1 = 24'(x_ff[0]);
   assign x0  = 24'(x_ff[1]);
   assign x1  = 24'(x_ff[2]);
   assign x2  = 24'(x_ff[3]);
   assign c1  = x1 - xm1;
   assign c2  = (xm1 <<< 1) - x0 * 24'sd5 + (x1 <<< 2) - x2;
   assign c3  = (x2 - xm1) + (x0 - x1) * 24'sd3;

   assign p8  = mul_p >>> 8;
   assign p16 = mul_p >>> 16;
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: hadd = c2;
         2'd1: hadd = c1;
         default: hadd = x0 <<< 1;
      endcase
   end
   assign acc_nx   = p16[23:0] + hadd;
   assign acc_half = acc_nx >>> 1;
   assign tap_v    = sat16(36'(acc_half));

   assign d_lb = 17'(a1_ff) - 17'(a0_ff);
   assign d_wf = 17'(wb_ff) - 17'(wa_ff);
   assign d_xf = 17'(curr_ff) - 17'(old_ff);
   assign wv   = sat16(36'(a0_ff) + $signed(p8[35:0]));
   assign bv   = sat16(36'(wa_ff) + $signed(p16[35:0]));
   assign xv   = sat16(36'(old_ff) + $signed(p16[35:0]));

   assign need_old = (cf_ff < mwr_pkg::OLD_IGNORED) && prev_v_ff;
   assign cf_sum   = 18'(cf_ff) + 18'(step_ff);
   assign wr_ok    = ({1'b0, in_wave} < 4'(mwr_pkg::WAVE_COUNT))
                     && ({1'b0, in_lvl} < 4'(mwr_pkg::MIP_LEVELS))
                     && (SW'(in_idx) < level_size(in_lvl));

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQ_M: begin
            mul_a = {2'b0, m_ff};
            mul_b = {2'b0, m_ff};
         end
         S_POS_M: begin
            mul_a = {10'b0, phase_ff};
            mul_b = {{(MW-SW){1'b0}}, sz - SW'(1)};
         end
         S_HRN_M: begin
            mul_a = (cnt_ff[1:0] == 2'd0) ? MW'(c3) : MW'(acc_ff);
            mul_b = {18'b0, t_ff};
         end
         S_LB_M: begin
            mul_a = MW'(d_lb);
            mul_b = {26'b0, lb_ff};
         end
         S_WF_M: begin
            mul_a = MW'(d_wf);
            mul_b = {18'b0, wf};
         end
         S_XF_M: begin
            mul_a = MW'(d_xf);
            mul_b = {17'b0, cf_ff};
         end
         default: ;
      endcase
   end

   // table port: writes in idle, tap reads otherwise
   always_comb begin
      st_req.we    = accept && (req_tuser == mwr_pkg::CMD_WRITE) && wr_ok;
      st_req.wdata = in_val;
      if (state_ff == S_IDLE) st_req.addr = addr_of(~bank_ff, in_wave, in_lvl, in_idx);
      else st_req.addr = addr_of(tb, tw, tl, ridx[IW-1:0]);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cf_in = cf_ff; bank_in = bank_ff; act_v_in = act_v_ff; prev_v_in = prev_v_ff;
      sr_in = sr_ff; morph_in = morph_ff; step_in = step_ff;
      phase_in = phase_ff; rem_in = rem_ff; qd_in = qd_ff; cnt_in = cnt_ff;
      e_in = e_ff; m_in = m_ff; fr_in = fr_ff;
      l0_in = l0_ff; l1_in = l1_ff; lb_in = lb_ff;
      bsel_in = bsel_ff; wsel_in = wsel_ff; lsel_in = lsel_ff;
      i0_in = i0_ff; t_in = t_ff; x_in = x_ff; acc_in = acc_ff;
      a0_in = a0_ff; a1_in = a1_ff; wa_in = wa_ff; wb_in = wb_ff;
      curr_in = curr_ff; old_in = old_ff; res_in = res_ff; isr_in = isr_ff; tk_in = tk_ff;
      rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff; rsp_u_in = rsp_u_ff;
      fin = 1'b0;
      fin_v = '0;

      if (csr_we) begin
         unique case (csr_addr)
            mwr_pkg::CSR_SAMPLE_RATE: sr_in = csr_wdata;
            mwr_pkg::CSR_MORPH:       morph_in = csr_wdata[15:0];
            mwr_pkg::CSR_BLEND_STEP:  step_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  mwr_pkg::CMD_SWAP: begin
                     tk_in = 1'b0;
                     if (cf_ff >= mwr_pkg::SWAP_READY) begin
                        prev_v_in = act_v_ff;
                        act_v_in  = 1'b1;
                        bank_in   = ~bank_ff;
                        cf_in     = '0;
                        tk_in     = 1'b1;
                     end
                     res_in = '0;
                     isr_in = 1'b0;
                     state_in = S_EMIT;
                  end
                  mwr_pkg::CMD_READ: begin
                     phase_in = in_phase;
                     qd_in    = {mag_ts, 16'b0};
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            rem_in = div_ge ? 18'(div_r - {1'b0, sr_eff}) : div_r[17:0];
            qd_in  = {qd_ff[DIVD_W-2:0], div_ge};
            cnt_in = cnt_ff + 6'd1;
            e_in   = 6'(DIVD_W - 1);
            if (cnt_ff == 6'(DIVD_W - 1)) state_in = S_NORM;
         end
         S_NORM: begin
            // quotient is never zero: dividend is far above the largest rate
            if (qd_ff[DIVD_W-1]) begin
               m_in = qd_ff[DIVD_W-1 -: 32];
               fr_in = '0;
               cnt_in = '0;
               state_in = S_SQ_M;
            end else begin
               qd_in = qd_ff << 1;
               e_in = e_ff - 6'd1;
            end
         end
         S_SQ_M: state_in = S_SQ_W;
         S_SQ_W: begin
            if (sq_sh[32]) begin
               m_in = sq_sh[32:1];
               fr_in = {fr_ff[6:0], 1'b1};
            end else begin
               m_in = sq_sh[31:0];
               fr_in = {fr_ff[6:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            state_in = (cnt_ff[2:0] == 3'd7) ? S_LVL : S_SQ_M;
         end
         S_LVL: begin
            l0_in = lvl_c[10:8];
            l1_in = (4'(lvl_c[10:8]) + 4'd1 < 4'(mwr_pkg::MIP_LEVELS))
                    ? lvl_c[10:8] + 3'd1 : 3'(mwr_pkg::MIP_LEVELS - 1);
            lb_in = lvl_c[7:0];
            wsel_in = 1'b0;
            lsel_in = 1'b0;
            if (act_v_ff) begin
               bsel_in = 1'b0;
               state_in = S_POS_M;
            end else begin
               curr_in = '0;
               if (need_old) begin
                  bsel_in = 1'b1;
                  state_in = S_POS_M;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         S_POS_M: state_in = S_POS_W;
         S_POS_W: begin
            i0_in = mul_p[24 +: IW];
            t_in = mul_p[23:8];
            cnt_in = '0;
            state_in = S_RD;
         end
         S_RD: begin
            // read issued at count k lands in the next cycle, from the table's output register
            if (cnt_ff[2:0] != 3'd0) x_in[2'(cnt_ff[2:0] - 3'd1)] = st_rdata;
            if (cnt_ff[2:0] == 3'd4) begin
               cnt_in = '0;
               state_in = S_HRN_M;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_HRN_M: state_in = S_HRN_W;
         S_HRN_W: begin
            acc_in = acc_nx;
            if (cnt_ff[1:0] == 2'd2) begin
               if (!lsel_ff) begin
                  a0_in = tap_v;
                  lsel_in = 1'b1;
                  state_in = S_POS_M;
               end else begin
                  a1_in = tap_v;
                  state_in = S_LB_M;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
               state_in = S_HRN_M;
            end
         end
         S_LB_M: state_in = S_LB_W;
         S_LB_W: begin
            lsel_in = 1'b0;
            if (!wsel_ff) begin
               wa_in = wv;
               wsel_in = 1'b1;
               state_in = S_POS_M;
            end else begin
               wb_in = wv;
               state_in = S_WF_M;
            end
         end
         S_WF_M: state_in = S_WF_W;
         S_WF_W: begin
            wsel_in = 1'b0;
            if (!bsel_ff) begin
               curr_in = bv;
               if (need_old) begin
                  bsel_in = 1'b1;
                  state_in = S_POS_M;
               end else begin
                  fin = 1'b1;
                  fin_v = bv;
               end
            end else begin
               old_in = bv;
               state_in = S_XF_M;
            end
         end
         S_XF_M: state_in = S_XF_W;
         S_XF_W: begin
            fin = 1'b1;
            fin_v = xv;
         end
         S_EMIT: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1;
               rsp_d_in = res_ff;
               rsp_u_in = {tk_ff, isr_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         res_in = fin_v;
         isr_in = 1'b1;
         tk_in = 1'b0;
         cf_in = (cf_sum > 18'(mwr_pkg::FADE_ONE)) ? mwr_pkg::FADE_ONE : cf_sum[16:0];
         state_in = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cf_ff     <= mwr_pkg::FADE_ONE;
         bank_ff   <= 1'b0;
         act_v_ff  <= 1'b0;
         prev_v_ff <= 1'b0;
         sr_ff     <= 18'd48000;
         morph_ff  <= '0;
         step_ff   <= 16'hffff;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cf_ff     <= cf_in;
         bank_ff   <= bank_in;
         act_v_ff  <= act_v_in;
         prev_v_ff <= prev_v_in;
         sr_ff     <= sr_in;
         morph_ff  <= morph_in;
         step_ff   <= step_in;
         rsp_v_ff  <= rsp_v_in;
      end
      phase_ff <= phase_in;
      rem_ff   <= rem_in;
      qd_ff    <= qd_in;
      cnt_ff   <= cnt_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      fr_ff    <= fr_in;
      l0_ff    <= l0_in;
      l1_ff    <= l1_in;
      lb_ff    <= lb_in;
      bsel_ff  <= bsel_in;
      wsel_ff  <= wsel_in;
      lsel_ff  <= lsel_in;
      i0_ff    <= i0_in;
      t_ff     <= t_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      a0_ff    <= a0_in;
      a1_ff    <= a1_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      curr_ff  <= curr_in;
      old_ff   <= old_in;
      res_ff   <= res_in;
      isr_ff   <= isr_in;
      tk_ff    <= tk_in;
      rsp_d_ff <= rsp_d_in;
      rsp_u_ff <= rsp_u_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;
   assign rsp_tuser  = rsp_u_ff;

   a_cf_range: assert property (@(posedge clock) disable iff (reset)
      cf_ff <= mwr_pkg::FADE_ONE)
      else $error("crossfade beyond one");

   a_swap_deferred: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == mwr_pkg::CMD_SWAP && cf_ff < mwr_pkg::SWAP_READY)
      |=> ($stable(bank_ff) && $stable(cf_ff)))
      else $error("deferred swap changed bank state");

   a_swap_taken: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == mwr_pkg::CMD_SWAP && cf_ff >= mwr_pkg::SWAP_READY)
      |=> (bank_ff != $past(bank_ff) && cf_ff == '0 && act_v_ff))
      else $error("taken swap did not flip bank");

   a_swap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("swap answer carries a sample");

endmodule
